@@ rtl/core/gated_mahalanobis_nearest_match_macros.svh @@
// assertion macros shared by the nearest-match checker
`ifndef GATED_MAHALANOBIS_NEAREST_MATCH_MACROS_SVH
`define GATED_MAHALANOBIS_NEAREST_MATCH_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define GMNM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define GMNM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/gmnm_pkg.sv @@
// shared types and constants for the gated nearest-match block
package gmnm_pkg;

    localparam int MAX_LANDMARKS = 64;
    localparam int IDX_W         = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1;
    localparam int COUNT_FIELD_W = 7;
    localparam int CNT_W_RAW     = $clog2(MAX_LANDMARKS + 1);
    localparam int CNT_W         = (CNT_W_RAW > COUNT_FIELD_W) ? CNT_W_RAW : COUNT_FIELD_W;
    localparam int SLOT_W        = 6;
    localparam int POS_W         = 32;
    localparam int DIST_W        = 64;
    localparam int ACC_W         = 100;
    localparam int CFG_IDX_W     = 2;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = 2;
    localparam int QCNT_W        = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_GATE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd1;

    localparam logic [31:0] GATE_RESET = 32'd19661;

    localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
    localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef struct packed {
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        logic signed [POS_W-1:0] wxx;
        logic signed [POS_W-1:0] wxy;
        logic signed [POS_W-1:0] wyx;
        logic signed [POS_W-1:0] wyy;
    } landmark_t;

    typedef struct packed {
        op_t              op;
        logic [IDX_W-1:0] slot;
        landmark_t        data;
        logic             last;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_OUT
    } back_state_t;

endpackage

@@ rtl/core/gated_mahalanobis_nearest_match.sv @@
// top level of the gated nearest-landmark match block
//
// Input channel (in_valid / in_stall): a load (operation 0) writes one landmark
// position and 2x2 weight matrix into slot entry_index; a query (operation 1)
// searches slots 0 .. landmark_count-1 for the smallest d*W*d' distance.
// Output channel (out_valid / out_stall): one result per query, none per load.
// Config channel (cfg_valid / cfg_ready, always ready): index 0 gate_threshold,
// index 1 landmark_count; other indexes are ignored. Write only while idle.
// A query occupies the back end for a pop, one table read per cycle into the
// s1..s7 distance pipeline, then posting the result. A load is written to the
// table in the cycle it is popped.
// Front holding stage and a 4-entry queue let loads and queries be taken while
// the back end scans or a result waits in the output register.
// Reset clears the queue, the pipeline and the output valid; gate_threshold
// returns to 19661 and landmark_count to 0. Table contents are kept undefined
// until loaded. A stalled result holds its payload; the back end then waits.
module gated_mahalanobis_nearest_match (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               operation,
    input  logic [gmnm_pkg::SLOT_W-1:0]        entry_index,
    input  logic signed [gmnm_pkg::POS_W-1:0]  pos_x,
    input  logic signed [gmnm_pkg::POS_W-1:0]  pos_y,
    input  logic signed [gmnm_pkg::POS_W-1:0]  mat_xx,
    input  logic signed [gmnm_pkg::POS_W-1:0]  mat_xy,
    input  logic signed [gmnm_pkg::POS_W-1:0]  mat_yx,
    input  logic signed [gmnm_pkg::POS_W-1:0]  mat_yy,
    input  logic                               last_observation,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               is_new,
    output logic [gmnm_pkg::SLOT_W-1:0]        match_index,
    output logic signed [gmnm_pkg::DIST_W-1:0] min_distance,
    output logic                               last_of_frame,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [gmnm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                        cfg_data
);

    logic [31:0]                        gate_reg;
    logic [gmnm_pkg::COUNT_FIELD_W-1:0] count_reg;
    gmnm_pkg::q_status_t                q_status;
    gmnm_pkg::cmd_t                     push_cmd;
    gmnm_pkg::cmd_t                     head_cmd;
    logic                               push;
    logic                               pop;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_reg  <= gmnm_pkg::GATE_RESET;
            count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == gmnm_pkg::CFG_GATE)
            begin
                gate_reg <= cfg_data;
            end
            else if (cfg_index == gmnm_pkg::CFG_COUNT)
            begin
                count_reg <= cfg_data[gmnm_pkg::COUNT_FIELD_W-1:0];
            end
        end
    end

    gmnm_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .operation        (operation),
        .entry_index      (entry_index),
        .pos_x            (pos_x),
        .pos_y            (pos_y),
        .mat_xx           (mat_xx),
        .mat_xy           (mat_xy),
        .mat_yx           (mat_yx),
        .mat_yy           (mat_yy),
        .last_observation (last_observation),
        .q_status         (q_status),
        .push             (push),
        .push_cmd         (push_cmd)
    );

    gmnm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (q_status)
    );

    gmnm_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_status       (q_status),
        .head_cmd       (head_cmd),
        .pop            (pop),
        .gate_threshold (gate_reg),
        .landmark_count (count_reg),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .is_new         (is_new),
        .match_index    (match_index),
        .min_distance   (min_distance),
        .last_of_frame  (last_of_frame)
    );

endmodule

@@ rtl/core/gmnm_front.sv @@
// front end: takes input items, classifies them and hands commands to the queue
module gmnm_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              operation,
    input  logic [gmnm_pkg::SLOT_W-1:0]       entry_index,
    input  logic signed [gmnm_pkg::POS_W-1:0] pos_x,
    input  logic signed [gmnm_pkg::POS_W-1:0] pos_y,
    input  logic signed [gmnm_pkg::POS_W-1:0] mat_xx,
    input  logic signed [gmnm_pkg::POS_W-1:0] mat_xy,
    input  logic signed [gmnm_pkg::POS_W-1:0] mat_yx,
    input  logic signed [gmnm_pkg::POS_W-1:0] mat_yy,
    input  logic                              last_observation,
    input  gmnm_pkg::q_status_t               q_status,
    output logic                              push,
    output gmnm_pkg::cmd_t                    push_cmd
);

    logic           cmd_valid_reg;
    logic           cmd_valid_next;
    gmnm_pkg::cmd_t cmd_reg;
    gmnm_pkg::cmd_t cmd_next;
    logic           accept;
    logic           slot_ok;
    logic           keep;

    // loads aimed beyond the table are dropped here
    assign slot_ok = (gmnm_pkg::CNT_W'(entry_index) < gmnm_pkg::CNT_W'(gmnm_pkg::MAX_LANDMARKS));
    assign keep    = (gmnm_pkg::op_t'(operation) == gmnm_pkg::OP_QUERY) || slot_ok;

    assign in_stall = cmd_valid_reg && q_status.full;
    assign accept   = in_valid && !in_stall;
    assign push     = cmd_valid_reg && !q_status.full;
    assign push_cmd = cmd_reg;

    // build the command word
    always_comb
    begin
        cmd_next.op       = gmnm_pkg::op_t'(operation);
        cmd_next.slot     = gmnm_pkg::IDX_W'(entry_index);
        cmd_next.data.px  = pos_x;
        cmd_next.data.py  = pos_y;
        cmd_next.data.wxx = mat_xx;
        cmd_next.data.wxy = mat_xy;
        cmd_next.data.wyx = mat_yx;
        cmd_next.data.wyy = mat_yy;
        cmd_next.last     = last_observation;
    end

    // holding stage valid
    always_comb
    begin
        if (accept && keep)
        begin
            cmd_valid_next = 1'b1;
        end
        else if (push)
        begin
            cmd_valid_next = 1'b0;
        end
        else
        begin
            cmd_valid_next = cmd_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    // holding stage payload
    always_ff @(posedge clk)
    begin
        if (accept && keep)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

@@ rtl/core/gmnm_queue.sv @@
// short command queue between front and back end
module gmnm_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  gmnm_pkg::cmd_t      push_cmd,
    input  logic                pop,
    output gmnm_pkg::cmd_t      head_cmd,
    output gmnm_pkg::q_status_t status
);

    gmnm_pkg::cmd_t              entry_reg [gmnm_pkg::QUEUE_DEPTH];
    logic [gmnm_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [gmnm_pkg::QPTR_W-1:0] wr_ptr_next;
    logic [gmnm_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [gmnm_pkg::QPTR_W-1:0] rd_ptr_next;
    logic [gmnm_pkg::QCNT_W-1:0] count_reg;
    logic [gmnm_pkg::QCNT_W-1:0] count_next;
    logic                        do_push;
    logic                        do_pop;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == gmnm_pkg::QCNT_W'(gmnm_pkg::QUEUE_DEPTH));
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_cmd     = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ rtl/core/gmnm_back.sv @@
// back end: landmark table, distance pipeline, minimum search and result register
module gmnm_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  gmnm_pkg::q_status_t                q_status,
    input  gmnm_pkg::cmd_t                     head_cmd,
    output logic                               pop,
    input  logic [31:0]                        gate_threshold,
    input  logic [gmnm_pkg::COUNT_FIELD_W-1:0] landmark_count,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               is_new,
    output logic [gmnm_pkg::SLOT_W-1:0]        match_index,
    output logic signed [gmnm_pkg::DIST_W-1:0] min_distance,
    output logic                               last_of_frame
);

    // control
    gmnm_pkg::back_state_t state_reg;
    gmnm_pkg::back_state_t state_next;
    logic [gmnm_pkg::CNT_W-1:0] n_eff;
    logic [gmnm_pkg::CNT_W-1:0] issue_cnt_reg;
    logic [gmnm_pkg::CNT_W-1:0] issue_cnt_next;
    logic                       issue;
    logic                       mem_we;
    logic                       start_query;
    logic                       out_load;
    logic                       pipe_busy;
    logic                       scan_done;

    // query context
    logic signed [gmnm_pkg::POS_W-1:0]  obs_x_reg;
    logic signed [gmnm_pkg::POS_W-1:0]  obs_y_reg;
    logic                               obs_last_reg;
    logic signed [gmnm_pkg::DIST_W-1:0] best_reg;
    logic signed [gmnm_pkg::DIST_W-1:0] best_next;
    logic [gmnm_pkg::IDX_W-1:0]         best_idx_reg;
    logic [gmnm_pkg::IDX_W-1:0]         best_idx_next;

    // landmark table
    gmnm_pkg::landmark_t mem [gmnm_pkg::MAX_LANDMARKS];

    // pipeline stage valids and tags
    logic                       s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic                       s5_valid_reg, s6_valid_reg, s7_valid_reg;
    logic [gmnm_pkg::IDX_W-1:0] s1_idx_reg, s2_idx_reg, s3_idx_reg, s4_idx_reg;
    logic [gmnm_pkg::IDX_W-1:0] s5_idx_reg, s6_idx_reg, s7_idx_reg;

    // pipeline payload
    gmnm_pkg::landmark_t                s1_lm_reg;
    logic signed [32:0]                 s2_dx_reg, s2_dy_reg;
    logic signed [31:0]                 s2_wxx_reg, s2_wxy_reg, s2_wyx_reg, s2_wyy_reg;
    logic signed [32:0]                 s3_dx_reg, s3_dy_reg;
    logic signed [64:0]                 s3_pxx_reg, s3_pyx_reg, s3_pxy_reg, s3_pyy_reg;
    logic signed [32:0]                 s4_dx_reg, s4_dy_reg;
    logic signed [65:0]                 s4_t1_reg, s4_t2_reg;
    logic signed [65:0]                 s5_q1h_reg, s5_q2h_reg;
    logic signed [66:0]                 s5_q1l_reg, s5_q2l_reg;
    logic signed [gmnm_pkg::ACC_W-1:0]  s6_acc_reg;
    logic signed [gmnm_pkg::DIST_W-1:0] s7_dist_reg;

    logic signed [32:0]                 dx_next, dy_next;
    logic signed [64:0]                 pxx_next, pyx_next, pxy_next, pyy_next;
    logic signed [65:0]                 t1_next, t2_next;
    logic signed [65:0]                 q1h_next, q2h_next;
    logic signed [66:0]                 q1l_next, q2l_next;
    logic signed [gmnm_pkg::ACC_W-1:0]  acc_next;
    logic signed [67:0]                 shifted;
    logic signed [gmnm_pkg::DIST_W-1:0] dist_next;
    logic                               gate_wins;
    logic                               new_result;

    // searched slot count, clamped to the table size
    always_comb
    begin
        if (gmnm_pkg::CNT_W'(landmark_count) > gmnm_pkg::CNT_W'(gmnm_pkg::MAX_LANDMARKS))
        begin
            n_eff = gmnm_pkg::CNT_W'(gmnm_pkg::MAX_LANDMARKS);
        end
        else
        begin
            n_eff = gmnm_pkg::CNT_W'(landmark_count);
        end
    end

    assign pipe_busy = s1_valid_reg || s2_valid_reg || s3_valid_reg || s4_valid_reg ||
                       s5_valid_reg || s6_valid_reg || s7_valid_reg;
    assign scan_done = (issue_cnt_reg == n_eff) && !pipe_busy;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gmnm_pkg::BK_IDLE:
            begin
                if (!q_status.empty && head_cmd.op == gmnm_pkg::OP_QUERY)
                begin
                    state_next = gmnm_pkg::BK_SCAN;
                end
            end
            gmnm_pkg::BK_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = gmnm_pkg::BK_OUT;
                end
            end
            gmnm_pkg::BK_OUT:
            begin
                if (!out_valid || !out_stall)
                begin
                    state_next = gmnm_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = gmnm_pkg::BK_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        pop         = 1'b0;
        mem_we      = 1'b0;
        start_query = 1'b0;
        issue       = 1'b0;
        out_load    = 1'b0;
        unique case (state_reg)
            gmnm_pkg::BK_IDLE:
            begin
                pop         = !q_status.empty;
                mem_we      = !q_status.empty && head_cmd.op == gmnm_pkg::OP_LOAD;
                start_query = !q_status.empty && head_cmd.op == gmnm_pkg::OP_QUERY;
            end
            gmnm_pkg::BK_SCAN:
            begin
                issue = (issue_cnt_reg < n_eff);
            end
            gmnm_pkg::BK_OUT:
            begin
                out_load = !out_valid || !out_stall;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    assign issue_cnt_next = start_query ? '0 : (issue ? issue_cnt_reg + 1'b1 : issue_cnt_reg);

    // running minimum; the first slot always takes the lead
    always_comb
    begin
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        if (start_query)
        begin
            best_next     = gmnm_pkg::DIST_MAX;
            best_idx_next = '0;
        end
        else if (s7_valid_reg && (s7_idx_reg == '0 || s7_dist_reg < best_reg))
        begin
            best_next     = s7_dist_reg;
            best_idx_next = s7_idx_reg;
        end
    end

    // gate acts as a last candidate: new only if strictly below the best distance
    assign gate_wins  = $signed({{(gmnm_pkg::DIST_W-32){1'b0}}, gate_threshold}) < best_reg;
    assign new_result = (n_eff == '0) || gate_wins;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gmnm_pkg::BK_IDLE;
            issue_cnt_reg <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            s7_valid_reg  <= 1'b0;
            out_valid     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_cnt_reg <= issue_cnt_next;
            s1_valid_reg  <= issue;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            s6_valid_reg  <= s5_valid_reg;
            s7_valid_reg  <= s6_valid_reg;
            if (out_load)
            begin
                out_valid <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    // table write and registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[head_cmd.slot] <= head_cmd.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_lm_reg <= mem[issue_cnt_reg[gmnm_pkg::IDX_W-1:0]];
        end
    end

    // offsets, the four matrix products, then their inner sums
    assign dx_next  = 33'(obs_x_reg) - 33'(s1_lm_reg.px);
    assign dy_next  = 33'(obs_y_reg) - 33'(s1_lm_reg.py);
    assign pxx_next = 65'(s2_dx_reg) * 65'(s2_wxx_reg);
    assign pyx_next = 65'(s2_dy_reg) * 65'(s2_wyx_reg);
    assign pxy_next = 65'(s2_dx_reg) * 65'(s2_wxy_reg);
    assign pyy_next = 65'(s2_dy_reg) * 65'(s2_wyy_reg);
    assign t1_next  = 66'(s3_pxx_reg) + 66'(s3_pyx_reg);
    assign t2_next  = 66'(s3_pxy_reg) + 66'(s3_pyy_reg);

    // outer products split into high and low halves of the inner sums
    assign q1h_next = 66'(s4_dx_reg) * 66'($signed(s4_t1_reg[65:33]));
    assign q1l_next = 67'(s4_dx_reg) * 67'($signed({1'b0, s4_t1_reg[32:0]}));
    assign q2h_next = 66'(s4_dy_reg) * 66'($signed(s4_t2_reg[65:33]));
    assign q2l_next = 67'(s4_dy_reg) * 67'($signed({1'b0, s4_t2_reg[32:0]}));
    assign acc_next = (gmnm_pkg::ACC_W'(s5_q1h_reg) <<< 33) + gmnm_pkg::ACC_W'(s5_q1l_reg) +
                      (gmnm_pkg::ACC_W'(s5_q2h_reg) <<< 33) + gmnm_pkg::ACC_W'(s5_q2l_reg);

    // floor to Q47.16 and saturate
    assign shifted = 68'(s6_acc_reg >>> 32);
    always_comb
    begin
        if (shifted[67:63] == 5'b00000 || shifted[67:63] == 5'b11111)
        begin
            dist_next = shifted[63:0];
        end
        else if (shifted[67])
        begin
            dist_next = gmnm_pkg::DIST_MIN;
        end
        else
        begin
            dist_next = gmnm_pkg::DIST_MAX;
        end
    end

    // datapath and context registers
    always_ff @(posedge clk)
    begin
        if (start_query)
        begin
            obs_x_reg    <= head_cmd.data.px;
            obs_y_reg    <= head_cmd.data.py;
            obs_last_reg <= head_cmd.last;
        end
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        s1_idx_reg   <= issue_cnt_reg[gmnm_pkg::IDX_W-1:0];
        s2_idx_reg   <= s1_idx_reg;
        s3_idx_reg   <= s2_idx_reg;
        s4_idx_reg   <= s3_idx_reg;
        s5_idx_reg   <= s4_idx_reg;
        s6_idx_reg   <= s5_idx_reg;
        s7_idx_reg   <= s6_idx_reg;
        s2_dx_reg    <= dx_next;
        s2_dy_reg    <= dy_next;
        s2_wxx_reg   <= s1_lm_reg.wxx;
        s2_wxy_reg   <= s1_lm_reg.wxy;
        s2_wyx_reg   <= s1_lm_reg.wyx;
        s2_wyy_reg   <= s1_lm_reg.wyy;
        s3_dx_reg    <= s2_dx_reg;
        s3_dy_reg    <= s2_dy_reg;
        s3_pxx_reg   <= pxx_next;
        s3_pyx_reg   <= pyx_next;
        s3_pxy_reg   <= pxy_next;
        s3_pyy_reg   <= pyy_next;
        s4_dx_reg    <= s3_dx_reg;
        s4_dy_reg    <= s3_dy_reg;
        s4_t1_reg    <= t1_next;
        s4_t2_reg    <= t2_next;
        s5_q1h_reg   <= q1h_next;
        s5_q1l_reg   <= q1l_next;
        s5_q2h_reg   <= q2h_next;
        s5_q2l_reg   <= q2l_next;
        s6_acc_reg   <= acc_next;
        s7_dist_reg  <= dist_next;
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            is_new        <= new_result;
            match_index   <= new_result ? '0 : gmnm_pkg::SLOT_W'(best_idx_reg);
            min_distance  <= best_reg;
            last_of_frame <= obs_last_reg;
        end
    end

endmodule

@@ rtl/core/gmnm_checker.sv @@
// port-level checks on the nearest-match block, bound to the top level
`include "gated_mahalanobis_nearest_match_macros.svh"

module gmnm_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic                               is_new,
    input logic [gmnm_pkg::SLOT_W-1:0]        match_index,
    input logic signed [gmnm_pkg::DIST_W-1:0] min_distance,
    input logic                               last_of_frame
);

    // a stalled result stays offered and unchanged
    `GMNM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped under stall")
    `GMNM_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(is_new) && $stable(match_index) && $stable(min_distance) && $stable(last_of_frame), "stalled result changed")

    // a new observation reports slot zero
    `GMNM_ASSERT_NOW(a_new_index, out_valid && is_new, match_index == '0, "new result with nonzero index")

    // the gate is never negative, so a new result beats it with a positive distance
    `GMNM_ASSERT_NOW(a_new_dist, out_valid && is_new, !min_distance[gmnm_pkg::DIST_W-1] && min_distance != '0, "new result with non-positive distance")

endmodule

bind gated_mahalanobis_nearest_match gmnm_checker u_gmnm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .is_new        (is_new),
    .match_index   (match_index),
    .min_distance  (min_distance),
    .last_of_frame (last_of_frame)
);
